>>> src/sktms_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key table package
// Widths, operation and status codes, and sequencer states shared by the
// sorted key table block.
// ----------------------------------------------------------------------------
`default_nettype none

package sktms_pkg;

  localparam int TableDepth = 1024;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = IdxW + 1;
  localparam int AddrW      = IdxW + 1;
  localparam int KeyW       = 32;
  localparam int TagW       = 16;
  localparam int RunW       = 11;
  localparam int OpW        = 2;
  localparam int StatW      = 2;
  localparam int EntryW     = KeyW + TagW;
  localparam int InDataW    = 64;
  localparam int OutDataW   = 40;

  localparam logic [OpW-1:0] OpAppend = 2'd0;
  localparam logic [OpW-1:0] OpMerge  = 2'd1;
  localparam logic [OpW-1:0] OpSearch = 2'd2;

  localparam logic [StatW-1:0] StatusOk   = 2'd0;
  localparam logic [StatW-1:0] StatusMiss = 2'd1;
  localparam logic [StatW-1:0] StatusFull = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SEARCH_PROBE,
    ST_SEARCH_CMP,
    ST_MERGE_READ,
    ST_MERGE_WRITE,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

>>> src/sorted_key_table_merge_search.sv
// ----------------------------------------------------------------------------
// Sorted key table with append, merge and binary search
// Keeps signed keys with payload tags in two banks of one dual-read memory.
//
// Usage: one operation per input transfer on the s_axis channel, one result
// per operation on the m_axis channel. Only one operation is in flight; the
// input side is ready only while the sequencer is idle.
// Steps from input transfer to result valid:
//   append: one write step, then done; op code three: straight to done.
//   search: up to log2(depth) + 1 = 11 probes, each one memory read and one
//           compare; a hit ends at the compare, a miss at the next probe.
//   merge:  each output entry takes one paired read of both run heads and
//           one write to the other bank.
// The sequencer returns to idle as the result is registered, and the input
// side is then ready for the next operation.
// Results sit in an output register; a new operation is accepted while an
// earlier result still waits. A finished operation holds in its last state
// until the output register is free, so a stalled receiver stalls intake.
// Reset empties the table (entry count zero, bank zero); memory contents are
// not cleared, and no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_merge_search (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // op[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // key[31:0], payload[47:32], run_length[58:48], zero[63:59]
  input  wire logic [63:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[1:0]
  output logic [1:0]       m_axis_tuser,
  // index[9:0], found_payload[25:10], entry_total[36:26], zero[39:37]
  output logic [39:0]      m_axis_tdata
);

  sktms_pkg::state_e state_q, state_d;

  logic [sktms_pkg::EntryW-1:0] mem_q [2*sktms_pkg::TableDepth];
  logic [sktms_pkg::EntryW-1:0] rd_a_q, rd_b_q;
  logic [sktms_pkg::AddrW-1:0]  rd_a_addr, rd_b_addr, wr_addr;
  logic [sktms_pkg::EntryW-1:0] wr_data;
  logic                         wr_en;

  logic                         bank_q, bank_d;
  logic [sktms_pkg::CntW-1:0]   count_q, count_d;
  logic [sktms_pkg::KeyW-1:0]   key_q, key_d;
  logic [sktms_pkg::TagW-1:0]   tag_q, tag_d;
  logic [sktms_pkg::CntW-1:0]   lo_q, lo_d, hix_q, hix_d;
  logic [sktms_pkg::IdxW-1:0]   mid_q, mid_d;
  logic [sktms_pkg::CntW-1:0]   mi_q, mi_d, mj_q, mj_d, mk_q, mk_d, div_q, div_d;
  logic [sktms_pkg::StatW-1:0]  res_status_q, res_status_d;
  logic [sktms_pkg::IdxW-1:0]   res_index_q, res_index_d;
  logic [sktms_pkg::TagW-1:0]   res_tag_q, res_tag_d;

  logic                         out_valid_q, out_valid_d;
  logic [sktms_pkg::StatW-1:0]  out_status_q, out_status_d;
  logic [sktms_pkg::IdxW-1:0]   out_index_q, out_index_d;
  logic [sktms_pkg::TagW-1:0]   out_tag_q, out_tag_d;
  logic [sktms_pkg::CntW-1:0]   out_total_q, out_total_d;

  logic                         in_xfer, out_free;
  logic [sktms_pkg::OpW-1:0]    in_op;
  logic [sktms_pkg::KeyW-1:0]   in_key;
  logic [sktms_pkg::TagW-1:0]   in_tag;
  logic [sktms_pkg::RunW-1:0]   in_run;
  logic [sktms_pkg::CntW-1:0]   run_sat;
  logic [sktms_pkg::CntW:0]     mid_sum;
  logic [sktms_pkg::IdxW-1:0]   mid_c;
  logic                         a_ok, b_ok, take_a, probe_lt;
  logic [sktms_pkg::KeyW-1:0]   key_a, key_b;

  assign in_op  = s_axis_tuser;
  assign in_key = s_axis_tdata[31:0];
  assign in_tag = s_axis_tdata[47:32];
  assign in_run = s_axis_tdata[58:48];

  assign s_axis_tready = (state_q == sktms_pkg::ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {3'b000, out_total_q, out_tag_q, out_index_q};

  assign run_sat = (sktms_pkg::CntW'(in_run) > count_q) ? count_q
                                                        : sktms_pkg::CntW'(in_run);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hix_q} - (sktms_pkg::CntW+1)'(1);
  assign mid_c   = mid_sum[sktms_pkg::IdxW:1];

  assign key_a    = rd_a_q[sktms_pkg::EntryW-1:sktms_pkg::TagW];
  assign key_b    = rd_b_q[sktms_pkg::EntryW-1:sktms_pkg::TagW];
  assign a_ok     = mi_q < div_q;
  assign b_ok     = mj_q < count_q;
  assign take_a   = a_ok && (!b_ok || ($signed(key_a) < $signed(key_b)));
  assign probe_lt = $signed(key_a) < $signed(key_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sktms_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_op)
            sktms_pkg::OpAppend: state_d = sktms_pkg::ST_APPEND;
            sktms_pkg::OpMerge:  state_d = sktms_pkg::ST_MERGE_READ;
            sktms_pkg::OpSearch: state_d = sktms_pkg::ST_SEARCH_PROBE;
            default:             state_d = sktms_pkg::ST_DONE;
          endcase
        end
      end
      sktms_pkg::ST_APPEND: state_d = sktms_pkg::ST_DONE;
      sktms_pkg::ST_SEARCH_PROBE: begin
        state_d = (lo_q < hix_q) ? sktms_pkg::ST_SEARCH_CMP : sktms_pkg::ST_DONE;
      end
      sktms_pkg::ST_SEARCH_CMP: begin
        state_d = (key_a == key_q) ? sktms_pkg::ST_DONE : sktms_pkg::ST_SEARCH_PROBE;
      end
      sktms_pkg::ST_MERGE_READ: begin
        state_d = (mk_q == count_q) ? sktms_pkg::ST_DONE : sktms_pkg::ST_MERGE_WRITE;
      end
      sktms_pkg::ST_MERGE_WRITE: state_d = sktms_pkg::ST_MERGE_READ;
      sktms_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = sktms_pkg::ST_IDLE;
        end
      end
      default: state_d = sktms_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    bank_d       = bank_q;
    count_d      = count_q;
    key_d        = key_q;
    tag_d        = tag_q;
    lo_d         = lo_q;
    hix_d        = hix_q;
    mid_d        = mid_q;
    mi_d         = mi_q;
    mj_d         = mj_q;
    mk_d         = mk_q;
    div_d        = div_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_tag_d    = res_tag_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    out_tag_d    = out_tag_q;
    out_total_d  = out_total_q;
    rd_a_addr    = {bank_q, mi_q[sktms_pkg::IdxW-1:0]};
    rd_b_addr    = {bank_q, mj_q[sktms_pkg::IdxW-1:0]};
    wr_addr      = {~bank_q, mk_q[sktms_pkg::IdxW-1:0]};
    wr_data      = take_a ? rd_a_q : rd_b_q;
    wr_en        = 1'b0;
    case (state_q)
      sktms_pkg::ST_IDLE: begin
        if (in_xfer) begin
          key_d        = in_key;
          tag_d        = in_tag;
          lo_d         = '0;
          hix_d        = count_q;
          mi_d         = '0;
          mj_d         = count_q - run_sat;
          mk_d         = '0;
          div_d        = count_q - run_sat;
          res_status_d = sktms_pkg::StatusOk;
          res_index_d  = '0;
          res_tag_d    = '0;
        end
      end
      sktms_pkg::ST_APPEND: begin
        wr_addr = {bank_q, count_q[sktms_pkg::IdxW-1:0]};
        wr_data = {key_q, tag_q};
        if (count_q >= sktms_pkg::CntW'(sktms_pkg::TableDepth)) begin
          res_status_d = sktms_pkg::StatusFull;
        end else begin
          wr_en       = 1'b1;
          res_index_d = count_q[sktms_pkg::IdxW-1:0];
          count_d     = count_q + 1'b1;
        end
      end
      sktms_pkg::ST_SEARCH_PROBE: begin
        rd_a_addr = {bank_q, mid_c};
        mid_d     = mid_c;
        if (!(lo_q < hix_q)) begin
          res_status_d = sktms_pkg::StatusMiss;
        end
      end
      sktms_pkg::ST_SEARCH_CMP: begin
        if (key_a == key_q) begin
          res_index_d = mid_q;
          res_tag_d   = rd_a_q[sktms_pkg::TagW-1:0];
        end else if (probe_lt) begin
          lo_d = sktms_pkg::CntW'(mid_q) + 1'b1;
        end else begin
          hix_d = sktms_pkg::CntW'(mid_q);
        end
      end
      sktms_pkg::ST_MERGE_READ: begin
        if (mk_q == count_q) begin
          bank_d = ~bank_q;
        end
      end
      sktms_pkg::ST_MERGE_WRITE: begin
        wr_en = 1'b1;
        mk_d  = mk_q + 1'b1;
        if (take_a) begin
          mi_d = mi_q + 1'b1;
        end else begin
          mj_d = mj_q + 1'b1;
        end
      end
      sktms_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_index_d  = res_index_q;
          out_tag_d    = res_tag_q;
          out_total_d  = count_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_a_q <= mem_q[rd_a_addr];
    rd_b_q <= mem_q[rd_b_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sktms_pkg::ST_IDLE;
      bank_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    tag_q        <= tag_d;
    lo_q         <= lo_d;
    hix_q        <= hix_d;
    mid_q        <= mid_d;
    mi_q         <= mi_d;
    mj_q         <= mj_d;
    mk_q         <= mk_d;
    div_q        <= div_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_tag_q    <= res_tag_d;
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
    out_tag_q    <= out_tag_d;
    out_total_q  <= out_total_d;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sktms_pkg::CntW'(sktms_pkg::TableDepth))
    else $error("entry count beyond table depth");

  a_merge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sktms_pkg::ST_MERGE_WRITE) |-> (mk_q < count_q && (a_ok || b_ok)))
    else $error("merge write with no entry left");

  a_full_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == sktms_pkg::StatusFull)
      |-> (m_axis_tdata[36:26] == sktms_pkg::CntW'(sktms_pkg::TableDepth)))
    else $error("table full reported below depth");

  a_search_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sktms_pkg::ST_SEARCH_CMP) |=> $stable(count_q) && $stable(bank_q))
    else $error("table changed during search");

endmodule

`default_nettype wire

>>> dv/key_table_checker.sv
// ----------------------------------------------------------------------------
// Sorted key table checker
// Watches both stream channels of the sorted key table. Keeps its own copy of
// the two banks, the live bank and the entry count, and predicts one result
// per input transfer. Compares each output transfer with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module key_table_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cmd_valid_i,
  input  wire logic                           cmd_ready_i,
  input  wire logic [sktms_pkg::OpW-1:0]      cmd_user_i,
  input  wire logic [sktms_pkg::InDataW-1:0]  cmd_data_i,
  input  wire logic                           rsp_valid_i,
  input  wire logic                           rsp_ready_i,
  input  wire logic [sktms_pkg::StatW-1:0]    rsp_user_i,
  input  wire logic [sktms_pkg::OutDataW-1:0] rsp_data_i,
  output int                                  fail_count_o,
  output int                                  open_count_o,
  output int                                  appends_o,
  output int                                  refusals_o,
  output int                                  merges_o,
  output int                                  hits_o,
  output int                                  misses_o,
  output int                                  idles_o
);

  typedef struct packed {
    logic [4:0]                 zero;
    logic [sktms_pkg::RunW-1:0] run_length;
    logic [sktms_pkg::TagW-1:0] payload;
    logic [sktms_pkg::KeyW-1:0] key;
    logic [sktms_pkg::OpW-1:0]  op;
  } table_cmd_t;

  typedef struct packed {
    logic [2:0]                  zero;
    logic [sktms_pkg::CntW-1:0]  entry_total;
    logic [sktms_pkg::TagW-1:0]  found_payload;
    logic [sktms_pkg::IdxW-1:0]  index;
    logic [sktms_pkg::StatW-1:0] status;
  } table_rsp_t;

  logic [sktms_pkg::KeyW-1:0] bank_key [2][sktms_pkg::TableDepth];
  logic [sktms_pkg::TagW-1:0] bank_tag [2][sktms_pkg::TableDepth];
  logic            live_bank;
  int              entry_cnt;
  table_rsp_t      pending_results [$];
  int              mismatches;
  int              tally_append, tally_full, tally_merge, tally_hit, tally_miss, tally_idle;

  function automatic table_rsp_t apply_table_op(table_cmd_t cmd);
    table_rsp_t rsp;
    int         lo, hi, mid, i, j, k, pick, split, run;
    logic       dst;
    rsp = '0;
    case (cmd.op)
      sktms_pkg::OpAppend: begin
        if (entry_cnt >= sktms_pkg::TableDepth) begin
          rsp.status = sktms_pkg::StatusFull;
          tally_full++;
        end else begin
          bank_key[live_bank][entry_cnt] = cmd.key;
          bank_tag[live_bank][entry_cnt] = cmd.payload;
          rsp.status = sktms_pkg::StatusOk;
          rsp.index  = sktms_pkg::IdxW'(entry_cnt);
          entry_cnt++;
          tally_append++;
        end
      end
      sktms_pkg::OpMerge: begin
        dst   = ~live_bank;
        run   = (int'(cmd.run_length) > entry_cnt) ? entry_cnt : int'(cmd.run_length);
        split = entry_cnt - run;
        i     = 0;
        j     = split;
        for (k = 0; k < entry_cnt; k++) begin
          if (i < split && (j >= entry_cnt ||
              $signed(bank_key[live_bank][i]) < $signed(bank_key[live_bank][j]))) begin
            pick = i;
            i++;
          end else begin
            pick = j;
            j++;
          end
          bank_key[dst][k] = bank_key[live_bank][pick];
          bank_tag[dst][k] = bank_tag[live_bank][pick];
        end
        live_bank  = dst;
        rsp.status = sktms_pkg::StatusOk;
        tally_merge++;
      end
      sktms_pkg::OpSearch: begin
        rsp.status = sktms_pkg::StatusMiss;
        lo = 0;
        hi = entry_cnt - 1;
        while (lo <= hi && rsp.status == sktms_pkg::StatusMiss) begin
          mid = (lo + hi) / 2;
          if (bank_key[live_bank][mid] == cmd.key) begin
            rsp.status        = sktms_pkg::StatusOk;
            rsp.index         = sktms_pkg::IdxW'(mid);
            rsp.found_payload = bank_tag[live_bank][mid];
          end else if ($signed(bank_key[live_bank][mid]) < $signed(cmd.key)) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
        if (rsp.status == sktms_pkg::StatusOk) tally_hit++;
        else tally_miss++;
      end
      default: begin
        rsp.status = sktms_pkg::StatusOk;
        tally_idle++;
      end
    endcase
    rsp.entry_total = sktms_pkg::CntW'(entry_cnt);
    return rsp;
  endfunction

  task automatic note_failure(input string what, input table_rsp_t want,
                              input table_rsp_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected status %0d index %0d payload %h total %0d",
               $time, what, want.status, want.index, want.found_payload, want.entry_total);
      $display("    got status %0d index %0d payload %h total %0d zero %b",
               seen.status, seen.index, seen.found_payload, seen.entry_total, seen.zero);
    end
  endtask

  always @(posedge clk_i) begin : watch
    table_rsp_t seen, want;
    if (!rst_ni) begin
      live_bank = 1'b0;
      entry_cnt = 0;
      pending_results.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        seen = {rsp_data_i, rsp_user_i};
        if (pending_results.size() == 0) begin
          note_failure("result with nothing outstanding", '0, seen);
        end else begin
          want = pending_results.pop_front();
          if (seen.status !== want.status || seen.index !== want.index ||
              seen.found_payload !== want.found_payload ||
              seen.entry_total !== want.entry_total || seen.zero !== 3'b000)
            note_failure("result mismatch", want, seen);
        end
      end
      if (cmd_valid_i && cmd_ready_i)
        pending_results.insert(pending_results.size(),
                               apply_table_op({cmd_data_i, cmd_user_i}));
    end
    fail_count_o <= mismatches;
    open_count_o <= pending_results.size();
    appends_o    <= tally_append;
    refusals_o   <= tally_full;
    merges_o     <= tally_merge;
    hits_o       <= tally_hit;
    misses_o     <= tally_miss;
    idles_o      <= tally_idle;
  end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// Sorted key table testbench
// Drives append, merge and search operations into the sorted key table:
// a directed opening on key extremes, tie order and run saturation, then
// mostly sorted runs followed by their merge mixed with searches and noise,
// then a closing stretch of appends, merges and searches without idling.
// A separate checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 64;
  localparam int RandomItems = 600;
  localparam int HoldCycles  = 300;
  localparam int HoldAfter   = 60;
  localparam int BatchMax    = 64;

  localparam logic [sktms_pkg::OpW-1:0] OpIdle = 2'd3;

  logic                               clk_i         = 1'b0;
  logic                               rst_ni        = 1'b0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [sktms_pkg::OpW-1:0]          s_axis_tuser  = '0;
  logic [sktms_pkg::InDataW-1:0]      s_axis_tdata  = '0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [sktms_pkg::StatW-1:0]        m_axis_tuser;
  logic [sktms_pkg::OutDataW-1:0]     m_axis_tdata;

  int fail_count, open_count, n_append, n_refused, n_merge, n_hit, n_miss, n_idle;
  int cycle_count = 0;
  int sent        = 0;
  int stored      = 0;
  bit quiet       = 1'b0;
  logic [sktms_pkg::KeyW-1:0] stored_keys [$];

  sorted_key_table_merge_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  key_table_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (s_axis_tvalid),
    .cmd_ready_i  (s_axis_tready),
    .cmd_user_i   (s_axis_tuser),
    .cmd_data_i   (s_axis_tdata),
    .rsp_valid_i  (m_axis_tvalid),
    .rsp_ready_i  (m_axis_tready),
    .rsp_user_i   (m_axis_tuser),
    .rsp_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .open_count_o (open_count),
    .appends_o    (n_append),
    .refusals_o   (n_refused),
    .merges_o     (n_merge),
    .hits_o       (n_hit),
    .misses_o     (n_miss),
    .idles_o      (n_idle)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic logic [sktms_pkg::KeyW-1:0] draw_key(bit narrow);
    if (narrow) return sktms_pkg::KeyW'($urandom_range(0, 16)) - sktms_pkg::KeyW'(8);
    return $urandom;
  endfunction

  function automatic logic [sktms_pkg::KeyW-1:0] probe_key();
    if (stored_keys.size() > 0 && $urandom_range(0, 3) != 0)
      return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    return draw_key(1'($urandom_range(0, 1)));
  endfunction

  task automatic offer(input logic [sktms_pkg::OpW-1:0] op,
                       input logic [sktms_pkg::KeyW-1:0] key,
                       input logic [sktms_pkg::TagW-1:0] tag,
                       input logic [sktms_pkg::RunW-1:0] run);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b00000, run, tag, key};
    do begin
      @(posedge clk_i);
    end while (s_axis_tready !== 1'b1);
    sent++;
    if (op == sktms_pkg::OpAppend && stored < sktms_pkg::TableDepth) begin
      stored++;
      stored_keys.insert(stored_keys.size(), key);
    end
    @(negedge clk_i);
  endtask

  // append a sorted run, then merge it into the table
  task automatic append_sorted_run(input int len, input bit narrow);
    logic [sktms_pkg::KeyW-1:0] run_keys [BatchMax];
    logic [sktms_pkg::KeyW-1:0] hold_key;
    int              a, b;
    for (a = 0; a < len; a++) run_keys[a] = draw_key(narrow);
    for (a = 1; a < len; a++) begin
      hold_key = run_keys[a];
      for (b = a; b > 0 && $signed(run_keys[b-1]) > $signed(hold_key); b--)
        run_keys[b] = run_keys[b-1];
      run_keys[b] = hold_key;
    end
    for (a = 0; a < len; a++)
      offer(sktms_pkg::OpAppend, run_keys[a], sktms_pkg::TagW'($urandom),
            sktms_pkg::RunW'($urandom));
    offer(sktms_pkg::OpMerge, $urandom, sktms_pkg::TagW'($urandom), sktms_pkg::RunW'(len));
  endtask

  initial begin : drive_ready
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && sent >= HoldAfter) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int mark, pick;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    offer(sktms_pkg::OpSearch, '0, '0, '0);
    offer(sktms_pkg::OpMerge, '0, '0, '0);
    offer(OpIdle, '1, '1, '1);
    offer(sktms_pkg::OpAppend, 32'h7FFF_FFFF, 16'hFFFF, 11'h7FF);
    offer(sktms_pkg::OpMerge, '1, '1, '0);
    offer(sktms_pkg::OpAppend, 32'h8000_0000, 16'h0000, '0);
    offer(sktms_pkg::OpAppend, 32'hFFFF_FFFF, 16'h0001, '0);
    offer(sktms_pkg::OpAppend, 32'h0000_0000, 16'h8000, '0);
    offer(sktms_pkg::OpMerge, '0, '0, 11'd3);
    // equal key in the tail run goes ahead of the head run
    offer(sktms_pkg::OpAppend, 32'hFFFF_FFFF, 16'h00A5, '0);
    offer(sktms_pkg::OpMerge, '0, '0, 11'd1);
    offer(sktms_pkg::OpSearch, 32'hFFFF_FFFF, '0, '0);
    offer(sktms_pkg::OpSearch, 32'h8000_0000, '1, '1);
    offer(sktms_pkg::OpSearch, 32'h7FFF_FFFF, '0, '0);
    offer(sktms_pkg::OpSearch, 32'h0000_0000, '0, '0);
    offer(sktms_pkg::OpSearch, 32'h0000_0005, '0, '0);
    offer(sktms_pkg::OpSearch, 32'h8000_0001, '0, '0);
    offer(sktms_pkg::OpMerge, '0, '0, 11'd1024);
    offer(sktms_pkg::OpMerge, '0, '0, 11'h7FF);
    offer(sktms_pkg::OpAppend, 32'h0000_0003, 16'h5A5A, '1);
    offer(sktms_pkg::OpMerge, '0, '0, 11'd1);
    offer(sktms_pkg::OpSearch, 32'h0000_0003, '0, '0);
    offer(OpIdle, '0, '0, '0);

    mark = sent;
    while (sent - mark < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        append_sorted_run($urandom_range(1, 6), $urandom_range(0, 3) == 0);
      else if (pick < 80)
        offer(sktms_pkg::OpSearch, probe_key(), sktms_pkg::TagW'($urandom),
              sktms_pkg::RunW'($urandom));
      else if (pick < 85)
        offer(sktms_pkg::OpAppend, draw_key(1'b0), sktms_pkg::TagW'($urandom),
              sktms_pkg::RunW'($urandom));
      else if (pick < 90)
        offer(sktms_pkg::OpMerge, $urandom, sktms_pkg::TagW'($urandom),
              sktms_pkg::RunW'($urandom));
      else if (pick < 95)
        offer(OpIdle, $urandom, sktms_pkg::TagW'($urandom), sktms_pkg::RunW'($urandom));
      else
        offer(sktms_pkg::OpSearch, draw_key(1'b1), sktms_pkg::TagW'($urandom),
              sktms_pkg::RunW'($urandom));
    end

    quiet = 1'b1;
    repeat (3) offer(sktms_pkg::OpAppend, $urandom, sktms_pkg::TagW'($urandom),
                     sktms_pkg::RunW'($urandom));
    offer(sktms_pkg::OpMerge, '0, '0, sktms_pkg::RunW'(sktms_pkg::TableDepth));
    repeat (12) offer(sktms_pkg::OpSearch, probe_key(), sktms_pkg::TagW'($urandom),
                      sktms_pkg::RunW'($urandom));
    offer(sktms_pkg::OpSearch, 32'h7FFF_FFFF, '0, '0);
    offer(sktms_pkg::OpSearch, 32'h8000_0000, '0, '0);
    offer(sktms_pkg::OpMerge, '0, '0, sktms_pkg::RunW'(BatchMax));
    offer(sktms_pkg::OpSearch, probe_key(), '0, '0);
    s_axis_tvalid <= 1'b0;

    while (open_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("ran %0d operations in %0d cycles: %0d appends, %0d refused when full, %0d merges",
             sent, cycle_count, n_append, n_refused, n_merge);
    $display("searches gave %0d hits and %0d misses; %0d no-op codes",
             n_hit, n_miss, n_idle);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sorted_key_table_merge_search.f
src/sktms_pkg.sv
src/sorted_key_table_merge_search.sv
dv/key_table_checker.sv
dv/tb_top.sv
